// ===== rtl/core/assert_macros.svh =====
// assertion macros for the rtl files (included by sha_ctrl.sv)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with active-low synchronous reset disable
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/core/sha_pkg.sv =====
// types, constants and round functions for the sha-256 hasher
package sha_pkg;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_PAD80,
        SRC_ZERO,
        SRC_LEN
    } t_src;

    typedef struct packed {
        logic       shift;
        t_src       src;
        logic [2:0] len_idx;
        logic       count_byte;
        logic       load;
        logic       round;
        logic [5:0] rnd;
        logic       add_hash;
        logic       clear;
        logic [2:0] word_sel;
    } t_dp_cmd;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] sml_s0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] sml_s1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== rtl/core/sha_if.sv =====
// request channels of the sha-256 hasher
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;

    modport source (output valid, digest_word, word_number, last_word, input ready);
    modport sink (input valid, digest_word, word_number, last_word, output ready);
endinterface

// ===== rtl/core/sha_datapath.sv =====
// block shift buffer, schedule window, round logic and hash words
module sha_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha_pkg::t_dp_cmd     i_cmd,
    input  logic [7:0]           i_data_byte,
    output logic [31:0]          o_digest
);

    logic [511:0] r_blk;
    logic [31:0]  r_w [0:15];
    logic [31:0]  r_v [0:7];
    logic [31:0]  r_h [0:7];
    logic [63:0]  r_bits;

    logic [7:0]  n_byte;
    logic [31:0] n_wt;
    logic [31:0] n_t1;
    logic [31:0] n_t2;
    logic [31:0] n_ch;
    logic [31:0] n_maj;
    logic [5:0]  n_lsel;

    always_comb begin
        n_lsel = {~i_cmd.len_idx, 3'b000};
        case (i_cmd.src)
            sha_pkg::SRC_DATA:  n_byte = i_data_byte;
            sha_pkg::SRC_PAD80: n_byte = sha_pkg::PAD_BYTE;
            sha_pkg::SRC_LEN:   n_byte = r_bits[n_lsel +: 8];
            default:            n_byte = 8'h00;
        endcase
    end

    // rotating window: r_w[0] is w[t] in the first 16 rounds, w[t-16] after
    always_comb begin
        if (i_cmd.rnd[5:4] == 2'b00) begin
            n_wt = r_w[0];
        end else begin
            n_wt = sha_pkg::sml_s1(r_w[14]) + r_w[9] + sha_pkg::sml_s0(r_w[1]) + r_w[0];
        end
        n_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        n_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        n_t1  = r_v[7] + sha_pkg::big_s1(r_v[4]) + n_ch + sha_pkg::ROUND_K[i_cmd.rnd] + n_wt;
        n_t2  = sha_pkg::big_s0(r_v[0]) + n_maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_blk <= {r_blk[503:0], n_byte};
        end
        if (i_cmd.load) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= r_blk[511 - 32*i -: 32];
            end
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= n_wt;
            r_v[0]  <= n_t1 + n_t2;
            r_v[1]  <= r_v[0];
            r_v[2]  <= r_v[1];
            r_v[3]  <= r_v[2];
            r_v[4]  <= r_v[3] + n_t1;
            r_v[5]  <= r_v[4];
            r_v[6]  <= r_v[5];
            r_v[7]  <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha_pkg::INIT_H[i];
            end
            r_bits <= 64'd0;
        end else begin
            if (i_cmd.add_hash) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (i_cmd.count_byte) begin
                r_bits <= r_bits + 64'd8;
            end
        end
    end

    assign o_digest = r_h[i_cmd.word_sel];

endmodule

// ===== rtl/core/sha_ctrl.sv =====
// sequencer for byte intake, padding, rounds and digest readout
`include "assert_macros.svh"

module sha_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_has_byte,
    input  logic             i_end_of_message,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [2:0]       o_word,
    output sha_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_P80,
        S_PZERO,
        S_PLEN,
        S_LOAD,
        S_COMP,
        S_ADD,
        S_OUT
    } t_state;

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    logic [5:0] r_fill, n_fill;
    logic [5:0] r_rnd, n_rnd;
    logic [2:0] r_word, n_word;
    logic       n_acc;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_fill  = r_fill;
        n_rnd   = r_rnd;
        n_word  = r_word;
        n_acc   = i_in_valid && (r_state == S_IDLE);
        o_cmd   = '0;
        o_cmd.src      = sha_pkg::SRC_DATA;
        o_cmd.len_idx  = r_fill[2:0];
        o_cmd.rnd      = r_rnd;
        o_cmd.word_sel = r_word;
        case (r_state)
            S_IDLE: begin
                if (n_acc && i_has_byte) begin
                    o_cmd.shift      = 1'b1;
                    o_cmd.count_byte = 1'b1;
                    n_fill = r_fill + 6'd1;
                    if (r_fill == sha_pkg::LAST_POS) begin
                        n_state = S_LOAD;
                        n_ret   = i_end_of_message ? S_P80 : S_IDLE;
                    end else if (i_end_of_message) begin
                        n_state = S_P80;
                    end
                end else if (n_acc && i_end_of_message) begin
                    n_state = S_P80;
                end
            end
            S_P80: begin
                o_cmd.shift = 1'b1;
                o_cmd.src   = sha_pkg::SRC_PAD80;
                n_fill = r_fill + 6'd1;
                n_state = S_PZERO;
                if (r_fill == sha_pkg::LAST_POS) begin
                    n_state = S_LOAD;
                    n_ret   = S_PZERO;
                end
            end
            S_PZERO: begin
                if (r_fill == sha_pkg::LEN_POS) begin
                    n_state = S_PLEN;
                end else begin
                    o_cmd.shift = 1'b1;
                    o_cmd.src   = sha_pkg::SRC_ZERO;
                    n_fill = r_fill + 6'd1;
                    if (r_fill == sha_pkg::LAST_POS) begin
                        n_state = S_LOAD;
                        n_ret   = S_PZERO;
                    end
                end
            end
            S_PLEN: begin
                o_cmd.shift = 1'b1;
                o_cmd.src   = sha_pkg::SRC_LEN;
                n_fill = r_fill + 6'd1;
                if (r_fill == sha_pkg::LAST_POS) begin
                    n_state = S_LOAD;
                    n_ret   = S_OUT;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_rnd   = 6'd0;
                n_state = S_COMP;
            end
            S_COMP: begin
                o_cmd.round = 1'b1;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == sha_pkg::LAST_POS) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add_hash = 1'b1;
                n_word  = 3'd0;
                n_state = r_ret;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_word = r_word + 3'd1;
                    if (r_word == 3'd7) begin
                        o_cmd.clear = 1'b1;
                        n_fill  = 6'd0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_fill  <= 6'd0;
            r_rnd   <= 6'd0;
            r_word  <= 3'd0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_rnd   <= n_rnd;
            r_word  <= n_word;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_word      = r_word;

    `ASSERT_CLK(a_no_overlap, i_clk, i_rst_n, !(o_in_ready && o_out_valid), "intake during readout")
    `ASSERT_CLK(a_len_next, i_clk, i_rst_n, (r_state == S_PZERO && r_fill == sha_pkg::LEN_POS) |=> (r_state == S_PLEN), "length not after zero fill")
    `ASSERT_CLK(a_back_idle, i_clk, i_rst_n, (o_out_valid && i_out_ready && r_word == 3'd7) |=> (o_in_ready && r_fill == 6'd0), "no return to idle after digest")
    `ASSERT_CLK(a_rounds_done, i_clk, i_rst_n, (r_state == S_ADD) |-> ($past(r_rnd) == sha_pkg::LAST_POS), "compression left early")

endmodule

// ===== rtl/core/sha256_message_hasher_top.sv =====
// sha-256 hasher top: one byte request in, eight digest word requests out
// a byte request is taken while idle; every 64th byte starts a compression (load, 64 rounds, hash add)
// the end request adds padding (0x80, zero fill, 64-bit length), one or two compressions, then 8 word requests
// one compression round per cycle through a single shared round unit
// synchronous active-low reset restores the initial hash and clears length and fill
module sha256_message_hasher_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sha_in_if.sink     i_in,
    sha_out_if.source  o_out
);

    sha_pkg::t_dp_cmd w_cmd;
    logic [31:0]      w_digest;
    logic [2:0]       w_word;

    sha_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in.valid),
        .i_has_byte       (i_in.has_byte),
        .i_end_of_message (i_in.end_of_message),
        .o_in_ready       (i_in.ready),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_word           (w_word),
        .o_cmd            (w_cmd)
    );

    sha_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_data_byte (i_in.data_byte),
        .o_digest    (w_digest)
    );

    assign o_out.digest_word = w_digest;
    assign o_out.word_number = w_word;
    assign o_out.last_word   = (w_word == 3'd7);

endmodule
